FILE: sv/dpp_pkg.sv
// Shared widths, register codes and defaults for the drift point to pad digitizer.
`timescale 1ns / 1ps
`default_nettype none
package dpp_pkg;
  localparam int XY_W            = 14;
  localparam int Z_W             = 15;
  localparam int E_W             = 24;
  localparam int PHI_W           = 24;
  localparam int SQ_IN_W         = 36;
  localparam int ROOT_W          = 18;
  localparam int CHAN_W          = 15;
  localparam int TDC_W           = 12;
  localparam int ADC_W           = 16;
  localparam int NPT_W           = 10;
  localparam int TZ_W            = 12;
  localparam int GAIN_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 12;
  localparam int PAD_COLUMNS_DEF = 100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIC_PERIOD = 2'd0,
    CFG_TIME_ZERO  = 2'd1,
    CFG_ADC_GAIN   = 2'd2
  } cfg_idx_t;
endpackage
`default_nettype wire

FILE: sv/drift_point_to_pad_digitizer.sv
// Top level: drift point to pad channel, TDC and ADC digitizer pipeline.
// Throughput: one point per cycle; busy stays low, results cannot be held off.
// Depth is set by the 18-stage square root and the 20-stage TDC divider.
// Reset clears all stage valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module drift_point_to_pad_digitizer import dpp_pkg::*; #(
  parameter int PAD_COLUMNS = PAD_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [XY_W-1:0] in_pos_x,
  input  logic signed [XY_W-1:0] in_pos_y,
  input  logic signed [Z_W-1:0]  in_pos_z,
  input  logic [E_W-1:0]         in_edep_ev,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_strobe,
  output logic [CHAN_W-1:0]      out_channel,
  output logic [TDC_W-1:0]       out_tdc_tics,
  output logic [ADC_W-1:0]       out_adc_counts,
  output logic                   out_in_range
);
  localparam int LAT    = 46;
  localparam int COL_W  = (PAD_COLUMNS > 1) ? $clog2(PAD_COLUMNS) : 1;
  localparam int DIV_W  = 20;
  localparam int AZ_DLY = 8;
  localparam int Z_DLY  = 27;
  localparam int AD_DLY = 42;
  localparam int CH_DLY = 16;

  localparam logic [NPT_W-1:0]  NPT_RESET  = NPT_W'(120);
  localparam logic [TZ_W-1:0]   TZ_RESET   = '0;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(20);

  localparam logic [22:0] DIV5_RECIP  = 23'd6710887;
  localparam logic [29:0] DIV125_RECIP = 30'd549755814;
  localparam logic [23:0] ROW_SCALE   = 24'd13176795;
  localparam logic [37:0] RAD_TO_TURN = 38'd174992710548;
  localparam logic [21:0] RT_HI       = RAD_TO_TURN[37:16];
  localparam logic [15:0] RT_LO       = RAD_TO_TURN[15:0];

  localparam logic signed [17:0] CT2 = -18'sd10761;
  localparam logic signed [17:0] CT1 = -18'sd6206;
  localparam logic signed [45:0] CT0_Q32 = 46'sd576723 <<< 16;
  localparam logic signed [17:0] CD2 = 18'sd1881;
  localparam logic signed [17:0] CD1 = -18'sd34957;
  localparam logic signed [45:0] CD0_Q32 = 46'sd153846 <<< 16;

  // configuration
  logic [NPT_W-1:0]  tic_period_r;
  logic [TZ_W-1:0]   time_zero_r;
  logic [GAIN_W-1:0] adc_gain_r;
  logic [NPT_W-1:0]  npt;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;
  assign npt       = (tic_period_r == '0) ? NPT_W'(1) : tic_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tic_period_r <= NPT_RESET;
      time_zero_r  <= TZ_RESET;
      adc_gain_r   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIC_PERIOD: tic_period_r <= cfg_data[NPT_W-1:0];
        CFG_TIME_ZERO:  time_zero_r  <= cfg_data[TZ_W-1:0];
        CFG_ADC_GAIN:   adc_gain_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits
  logic [LAT:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-1:0], start && !busy};
    end
  end

  // s0: input capture
  logic signed [XY_W-1:0] x0_r;
  logic signed [XY_W-1:0] y0_r;
  logic signed [Z_W-1:0]  z0_r;
  logic [E_W-1:0]         e0_r;

  always_ff @(posedge clk) begin
    x0_r <= in_pos_x;
    y0_r <= in_pos_y;
    z0_r <= in_pos_z;
    e0_r <= in_edep_ev;
  end

  // s1: squared radius, ADC product
  logic signed [2*XY_W-1:0] sqx;
  logic signed [2*XY_W-1:0] sqy;
  logic [2*XY_W-1:0]        r2_r;
  logic [31:0]              adcp_r;

  assign sqx = x0_r * x0_r;
  assign sqy = y0_r * y0_r;

  always_ff @(posedge clk) begin
    r2_r   <= $unsigned(sqx) + $unsigned(sqy);
    adcp_r <= 32'(adc_gain_r * e0_r);
  end

  // ADC: floor(n / 1000) as floor(floor(n / 8) / 125), s2..s3
  logic [58:0]      adcq_r;
  logic [22:0]      adc_nxt;
  logic [ADC_W-1:0] adc_r;
  logic [ADC_W-1:0] adc_dly_r [AD_DLY];

  assign adc_nxt = adcq_r[58:36];

  always_ff @(posedge clk) begin
    adcq_r <= 59'(adcp_r[31:3] * DIV125_RECIP);
    adc_r  <= (adc_nxt[22:16] != '0) ? '1 : adc_nxt[15:0];
    adc_dly_r[0] <= adc_r;
    for (int i = 1; i < AD_DLY; i++) adc_dly_r[i] <= adc_dly_r[i-1];
  end

  // radius s2..s19, azimuth s1..s17
  logic [ROOT_W-1:0] rr;
  logic [PHI_W-1:0]  az;
  logic [PHI_W-1:0]  az_dly_r [AZ_DLY];

  dpp_isqrt u_isqrt (
    .clk      (clk),
    .in_val   ({r2_r, 8'd0}),
    .out_root (rr)
  );

  dpp_cordic u_cordic (
    .clk     (clk),
    .in_x    (x0_r),
    .in_y    (y0_r),
    .out_phi (az)
  );

  always_ff @(posedge clk) begin
    az_dly_r[0] <= az;
    for (int i = 1; i < AZ_DLY; i++) az_dly_r[i] <= az_dly_r[i-1];
  end

  // s20..s23: radius in Q16 cm and both quadratics
  logic [45:0]        p5_r;
  logic [20:0]        s_nxt;
  logic [20:0]        s_r;
  logic [41:0]        sq_r;
  logic [25:0]        s2_nxt;
  logic signed [45:0] pa_r;
  logic signed [45:0] pb_r;
  logic signed [45:0] qa_r;
  logic signed [45:0] qb_r;
  logic signed [45:0] pt_r;
  logic signed [45:0] pd_r;

  assign s_nxt  = p5_r[45:25];
  assign s2_nxt = sq_r[41:16];

  always_ff @(posedge clk) begin
    p5_r <= 46'({rr, 5'd0} * DIV5_RECIP);
    s_r  <= s_nxt;
    sq_r <= 42'(s_nxt * s_nxt);
    pa_r <= 46'(CT2 * $signed({1'b0, s2_nxt}));
    pb_r <= 46'(CT1 * $signed({1'b0, s_r}));
    qa_r <= 46'(CD2 * $signed({1'b0, s2_nxt}));
    qb_r <= 46'(CD1 * $signed({1'b0, s_r}));
    pt_r <= pa_r + pb_r + CT0_Q32;
    pd_r <= qa_r + qb_r + CD0_Q32;
  end

  // s24..s25: time scale, azimuth drift in Q24 turns
  logic signed [55:0]  pt1000_r;
  logic signed [29:0]  dq_nxt;
  logic signed [53:0]  dqh_r;
  logic signed [47:0]  dql_r;
  logic [69:0]         dsum;
  logic [PHI_W-1:0]    d24_r;
  logic [DIV_W-1:0]    tq_nxt;
  logic                tq_neg_r;
  logic [DIV_W-1:0]    tq_mag_r;

  assign dq_nxt = pd_r[45:16];
  assign dsum   = {dqh_r, 16'd0} + {{22{dql_r[47]}}, dql_r};
  assign tq_nxt = pt1000_r[51:32];

  always_ff @(posedge clk) begin
    pt1000_r <= 56'(pt_r * $signed(11'sd1000));
    dqh_r    <= 54'(dq_nxt * $signed({1'b0, RT_HI}));
    dql_r    <= 48'(dq_nxt * $signed({1'b0, RT_LO}));
    d24_r    <= dsum[55:32];
    tq_neg_r <= tq_nxt[DIV_W-1];
    tq_mag_r <= tq_nxt[DIV_W-1] ? DIV_W'(-tq_nxt) : tq_nxt;
  end

  // s26..s29: drifted azimuth, row, column, channel
  logic [PHI_W-1:0]       phi_r;
  logic [47:0]            rowp_r;
  logic signed [Z_W-1:0]  z_dly_r [Z_DLY];
  logic [7:0]             row_nxt;
  logic [16:0]            ncol;
  logic                   far_neg;
  logic                   over;
  logic [COL_W-1:0]       col_nxt;
  logic [7:0]             row_r;
  logic [COL_W-1:0]       col_r;
  logic                   ok_r;
  logic [18:0]            chan_full;
  logic [CHAN_W-1:0]      chan_dly_r [CH_DLY+1];
  logic                   ok_dly_r   [CH_DLY+1];

  assign row_nxt = rowp_r[47:40];
  assign ncol    = {{2{z_dly_r[Z_DLY-1][Z_W-1]}}, z_dly_r[Z_DLY-1]} + 17'd12800
                   - {9'd0, row_nxt[1:0], 6'd0};
  assign far_neg = ncol[16] && (ncol[15:0] <= 16'hFF00);
  assign over    = !ncol[16] && ({2'b00, ncol[16:8]} > 11'(PAD_COLUMNS - 1));

  always_comb begin
    priority if (ncol[16]) begin
      col_nxt = '0;
    end else if (over) begin
      col_nxt = COL_W'(PAD_COLUMNS - 1);
    end else begin
      col_nxt = COL_W'(ncol[16:8]);
    end
  end

  assign chan_full = 19'(row_r) * 19'(PAD_COLUMNS) + 19'(col_r);

  always_ff @(posedge clk) begin
    z_dly_r[0] <= z0_r;
    for (int i = 1; i < Z_DLY; i++) z_dly_r[i] <= z_dly_r[i-1];
    phi_r  <= az_dly_r[AZ_DLY-1] - d24_r;
    rowp_r <= 48'(phi_r * ROW_SCALE);
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    ok_r   <= !far_neg && !over;
    chan_dly_r[0] <= chan_full[CHAN_W-1:0];
    ok_dly_r[0]   <= ok_r;
    for (int i = 1; i <= CH_DLY; i++) begin
      chan_dly_r[i] <= chan_dly_r[i-1];
      ok_dly_r[i]   <= ok_dly_r[i-1];
    end
  end

  // s26..s45: restoring divider of the time magnitude by the tic period
  logic [NPT_W-1:0] drem_r [DIV_W];
  logic [DIV_W-1:0] dnum_r [DIV_W];
  logic             dneg_r [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [NPT_W-1:0] rem_in;
    logic [DIV_W-1:0] num_in;
    logic             neg_in;
    logic [NPT_W:0]   rt;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = tq_mag_r;
      assign neg_in = tq_neg_r;
    end else begin : g_next
      assign rem_in = drem_r[k-1];
      assign num_in = dnum_r[k-1];
      assign neg_in = dneg_r[k-1];
    end

    assign rt = {rem_in, num_in[DIV_W-1]};
    assign ge = (rt >= {1'b0, npt});

    always_ff @(posedge clk) begin
      drem_r[k] <= ge ? NPT_W'(rt - {1'b0, npt}) : NPT_W'(rt);
      dnum_r[k] <= {num_in[DIV_W-2:0], ge};
      dneg_r[k] <= neg_in;
    end
  end

  // s46: floor for negative times, offset, saturation
  logic [DIV_W+1:0] qe;
  logic [DIV_W+1:0] qs;
  logic [DIV_W+1:0] tsum;
  logic [TDC_W-1:0] tdc_nxt;

  assign qe   = {2'b00, dnum_r[DIV_W-1]};
  assign qs   = dneg_r[DIV_W-1] ? ((DIV_W+2)'(0) - qe - (DIV_W+2)'(drem_r[DIV_W-1] != '0))
                                : qe;
  assign tsum = qs + (DIV_W+2)'(time_zero_r);

  always_comb begin
    priority if (tsum[DIV_W+1]) begin
      tdc_nxt = '0;
    end else if (tsum[DIV_W:TDC_W] != '0) begin
      tdc_nxt = '1;
    end else begin
      tdc_nxt = tsum[TDC_W-1:0];
    end
  end

  logic [CHAN_W-1:0] out_channel_r;
  logic [TDC_W-1:0]  out_tdc_r;
  logic [ADC_W-1:0]  out_adc_r;
  logic              out_ok_r;

  always_ff @(posedge clk) begin
    out_channel_r <= chan_dly_r[CH_DLY];
    out_ok_r      <= ok_dly_r[CH_DLY];
    out_adc_r     <= adc_dly_r[AD_DLY-1];
    out_tdc_r     <= tdc_nxt;
  end

  assign out_strobe     = vld_r[LAT];
  assign out_channel    = out_channel_r;
  assign out_tdc_tics   = out_tdc_r;
  assign out_adc_counts = out_adc_r;
  assign out_in_range   = out_ok_r;
endmodule
`default_nettype wire

FILE: sv/dpp_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module dpp_isqrt import dpp_pkg::*; (
  input  logic                 clk,
  input  logic [SQ_IN_W-1:0]   in_val,
  output logic [ROOT_W-1:0]    out_root
);
  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]   rem_r  [STEPS];
  logic [ROOT_W-1:0]  root_r [STEPS];
  logic [SQ_IN_W-1:0] val_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic [SQ_IN_W-1:0] val_in;
    logic [REM_W+1:0]   rem_t;
    logic [REM_W+1:0]   trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = in_val;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign val_in  = val_r[k-1];
    end

    assign rem_t = {rem_in, val_in[SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
      root_r[k] <= {root_in[ROOT_W-2:0], ge};
      val_r[k]  <= {val_in[SQ_IN_W-3:0], 2'b00};
    end
  end

  assign out_root = root_r[STEPS-1];
endmodule
`default_nettype wire

FILE: sv/dpp_cordic.sv
// Pipelined 16-step vectoring CORDIC giving the azimuth in Q24 turns.
`timescale 1ns / 1ps
`default_nettype none
module dpp_cordic import dpp_pkg::*; (
  input  logic                   clk,
  input  logic signed [XY_W-1:0] in_x,
  input  logic signed [XY_W-1:0] in_y,
  output logic [PHI_W-1:0]       out_phi
);
  localparam int STEPS = 16;
  localparam int CW    = XY_W + 16 + 4;
  localparam int ANG_W = PHI_W + 2;
  localparam logic [21:0] ATAN_Q24 [STEPS] = '{
    22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
    22'd41718, 22'd20860, 22'd10430, 22'd5215, 22'd2608, 22'd1304, 22'd652,
    22'd326, 22'd163, 22'd81
  };
  localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(1) << (PHI_W - 1);

  logic signed [CW-1:0]    cx_r   [STEPS+1];
  logic signed [CW-1:0]    cy_r   [STEPS+1];
  logic signed [ANG_W-1:0] z_r    [STEPS+1];
  logic                    zero_r [STEPS+1];

  logic signed [CW-1:0] x_ext;
  logic signed [CW-1:0] y_ext;
  logic                 x_neg;

  assign x_ext = {{(CW-XY_W-16){in_x[XY_W-1]}}, in_x, 16'd0};
  assign y_ext = {{(CW-XY_W-16){in_y[XY_W-1]}}, in_y, 16'd0};
  assign x_neg = in_x[XY_W-1];

  always_ff @(posedge clk) begin
    cx_r[0]   <= x_neg ? -x_ext : x_ext;
    cy_r[0]   <= x_neg ? -y_ext : y_ext;
    z_r[0]    <= x_neg ? $signed(HALF_TURN) : '0;
    zero_r[0] <= (in_x == '0) && (in_y == '0);
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (!cy_r[i][CW-1]) begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        z_r[i+1]  <= z_r[i] + $signed(ANG_W'(ATAN_Q24[i]));
      end else begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        z_r[i+1]  <= z_r[i] - $signed(ANG_W'(ATAN_Q24[i]));
      end
      zero_r[i+1] <= zero_r[i];
    end
  end

  assign out_phi = zero_r[STEPS] ? '0 : z_r[STEPS][PHI_W-1:0];
endmodule
`default_nettype wire
